// ===== design/utf8_sanitizer_assert.svh =====
// ----------------------------------------------------------------------------
// utf8_sanitizer assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_ASSERT_SVH
`define UTF8_SANITIZER_ASSERT_SVH

// same-cycle implication
`define U8S_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define U8S_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/u8s_pkg.sv =====
// ----------------------------------------------------------------------------
// u8s_pkg
// Types and constants shared by the UTF-8 sanitizer controller and datapath.
// ----------------------------------------------------------------------------
package u8s_pkg;

	localparam logic [7:0] REPL_B0 = 8'hef;
	localparam logic [7:0] REPL_B1 = 8'hbf;
	localparam logic [7:0] REPL_B2 = 8'hbd;

	localparam logic [1:0] REPL_LAST = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_COPY,
		ST_REPL,
		ST_FIN
	} state_t;

	// what the sequence at the head of the buffer calls for
	typedef enum logic [1:0] {
		CLS_EMPTY,
		CLS_COPY,
		CLS_REPL,
		CLS_HOLD
	} cls_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic       emit_repl;
		logic [1:0] repl_idx;
		logic       shift;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		cls_t       cls;
		logic [1:0] k_m1;
		logic       adv_ok;
	} sts_t;

endpackage

// ===== design/u8s_in_if.sv =====
// ----------------------------------------------------------------------------
// u8s_in_if
// Input channel: one raw text byte per word.
// ----------------------------------------------------------------------------
interface u8s_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_end;

	modport source (output valid, output in_byte, output text_end, input ready);
	modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

// ===== design/u8s_out_if.sv =====
// ----------------------------------------------------------------------------
// u8s_out_if
// Output channel: one sanitized byte per word plus framing flags.
// ----------------------------------------------------------------------------
interface u8s_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       is_replacement;
	logic       text_done;
	logic       text_valid;

	modport source (output valid, output out_byte, output run_last, output is_replacement,
		output text_done, output text_valid, input ready);
	modport sink (input valid, input out_byte, input run_last, input is_replacement,
		input text_done, input text_valid, output ready);
endinterface

// ===== design/u8s_ctrl.sv =====
// ----------------------------------------------------------------------------
// u8s_ctrl
// Sequencer: accepts a byte, classifies the buffer head, walks the emit
// cycles of each sequence or replacement, then closes the step.
// ----------------------------------------------------------------------------
module u8s_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  u8s_pkg::sts_t  sts,
	output u8s_pkg::cmd_t  cmd
);

	u8s_pkg::state_t state_q, state_d;
	logic [1:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8s_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == u8s_pkg::ST_EVAL) begin
				cnt_q <= (sts.cls == u8s_pkg::CLS_COPY) ? sts.k_m1 : 2'd0;
			end else if (sts.adv_ok && state_q == u8s_pkg::ST_COPY) begin
				cnt_q <= cnt_q - 2'd1;
			end else if (sts.adv_ok && state_q == u8s_pkg::ST_REPL) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			u8s_pkg::ST_IDLE: begin
				if (in_valid) state_d = u8s_pkg::ST_EVAL;
			end
			u8s_pkg::ST_EVAL: begin
				unique case (sts.cls)
					u8s_pkg::CLS_COPY: state_d = u8s_pkg::ST_COPY;
					u8s_pkg::CLS_REPL: state_d = u8s_pkg::ST_REPL;
					default:           state_d = u8s_pkg::ST_FIN;
				endcase
			end
			u8s_pkg::ST_COPY: begin
				if (sts.adv_ok && cnt_q == 2'd0) state_d = u8s_pkg::ST_EVAL;
			end
			u8s_pkg::ST_REPL: begin
				if (sts.adv_ok && cnt_q == u8s_pkg::REPL_LAST) state_d = u8s_pkg::ST_EVAL;
			end
			u8s_pkg::ST_FIN: begin
				if (sts.adv_ok) state_d = u8s_pkg::ST_IDLE;
			end
			default: state_d = u8s_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			u8s_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			u8s_pkg::ST_COPY: begin
				cmd.emit  = sts.adv_ok;
				cmd.shift = sts.adv_ok;
			end
			u8s_pkg::ST_REPL: begin
				cmd.emit      = sts.adv_ok;
				cmd.emit_repl = 1'b1;
				cmd.repl_idx  = cnt_q;
				cmd.shift     = sts.adv_ok && cnt_q == u8s_pkg::REPL_LAST;
			end
			u8s_pkg::ST_FIN: begin
				cmd.finish = sts.adv_ok;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/u8s_dp.sv =====
// ----------------------------------------------------------------------------
// u8s_dp
// Datapath: byte buffer, classifier, one-word lookahead stage that marks
// the last word of a step, output register, error flag.
// ----------------------------------------------------------------------------
module u8s_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    in_byte,
	input  logic          text_end,
	input  u8s_pkg::cmd_t cmd,
	output u8s_pkg::sts_t sts,
	u8s_out_if.source     dout
);

	`include "utf8_sanitizer_assert.svh"

	logic [7:0] buf_q [4];
	logic [2:0] cnt_q;
	logic       end_q;
	logic       err_q;
	logic       held_v_q;
	logic [7:0] held_byte_q;
	logic       held_repl_q;
	logic       out_v_q;
	logic       push_ok;
	logic       push;
	logic [7:0] emit_byte;
	logic       out_repl_ok;

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic u8s_pkg::sts_t classify(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] avail,
		input logic fin);
		logic [2:0]    k;
		logic          bad;
		logic          over;
		logic [20:0]   cp;
		u8s_pkg::sts_t s;
		s = '0;
		priority if (!b0[7])                  k = 3'd1;
		else if ((b0 & 8'he0) == 8'hc0)       k = 3'd2;
		else if ((b0 & 8'hf0) == 8'he0)       k = 3'd3;
		else if ((b0 & 8'hf8) == 8'hf0)       k = 3'd4;
		else                                  k = 3'd0;
		bad = (avail > 3'd1 && k > 3'd1 && !is_cont(b1))
			|| (avail > 3'd2 && k > 3'd2 && !is_cont(b2))
			|| (avail > 3'd3 && k > 3'd3 && !is_cont(b3));
		unique case (k)
			3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
			3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			default: cp = '0;
		endcase
		over = (k == 3'd2 && cp < 21'h80)
			|| (k == 3'd3 && (cp < 21'h800 || (cp >= 21'hd800 && cp <= 21'hdfff)))
			|| (k == 3'd4 && (cp < 21'h10000 || cp > 21'h10ffff));
		s.k_m1 = 2'(k - 3'd1);
		priority if (avail == 3'd0) s.cls = u8s_pkg::CLS_EMPTY;
		else if (k == 3'd1)         s.cls = u8s_pkg::CLS_COPY;
		else if (k == 3'd0 || bad)  s.cls = u8s_pkg::CLS_REPL;
		else if (avail < k)         s.cls = fin ? u8s_pkg::CLS_REPL : u8s_pkg::CLS_HOLD;
		else if (over)              s.cls = u8s_pkg::CLS_REPL;
		else                        s.cls = u8s_pkg::CLS_COPY;
		return s;
	endfunction

	assign push_ok = !out_v_q || dout.ready;
	assign push    = held_v_q && (cmd.emit || cmd.finish);

	always_comb begin
		sts        = classify(buf_q[0], buf_q[1], buf_q[2], buf_q[3], cnt_q, end_q);
		sts.adv_ok = !held_v_q || push_ok;
	end

	always_comb begin
		if (!cmd.emit_repl) begin
			emit_byte = buf_q[0];
		end else begin
			unique case (cmd.repl_idx)
				2'd0:    emit_byte = u8s_pkg::REPL_B0;
				2'd1:    emit_byte = u8s_pkg::REPL_B1;
				default: emit_byte = u8s_pkg::REPL_B2;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[cnt_q[1:0]] <= in_byte;
		end else if (cmd.shift) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
			buf_q[2] <= buf_q[3];
		end
		if (cmd.load) end_q <= text_end;
		if (cmd.emit) begin
			held_byte_q <= emit_byte;
			held_repl_q <= cmd.emit_repl;
		end
		if (push) begin
			dout.out_byte       <= held_byte_q;
			dout.is_replacement <= held_repl_q;
			dout.run_last       <= cmd.finish;
			dout.text_done      <= cmd.finish && end_q;
			dout.text_valid     <= cmd.finish && end_q && !err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			err_q    <= 1'b0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (cmd.shift) begin
				cnt_q <= cnt_q - 3'd1;
			end else if (cmd.finish && end_q) begin
				cnt_q <= '0;
			end
			if (cmd.emit && cmd.emit_repl) begin
				err_q <= 1'b1;
			end else if (cmd.finish && end_q) begin
				err_q <= 1'b0;
			end
			if (cmd.emit) begin
				held_v_q <= 1'b1;
			end else if (cmd.finish) begin
				held_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (dout.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign dout.valid = out_v_q;

	assign out_repl_ok = dout.out_byte == u8s_pkg::REPL_B0
		|| dout.out_byte == u8s_pkg::REPL_B1
		|| dout.out_byte == u8s_pkg::REPL_B2;

	`U8S_ASSERT_IMP(a_load_room, cmd.load, cnt_q <= 3'd3, "load with full buffer")
	`U8S_ASSERT_NXT(a_end_clears, cmd.finish && end_q, cnt_q == 3'd0 && !err_q, "text end left state")
	`U8S_ASSERT_IMP(a_done_last, dout.valid && dout.text_done, dout.run_last, "done word not last")
	`U8S_ASSERT_IMP(a_end_has_word, cmd.finish && end_q, held_v_q, "text end with no word")
	`U8S_ASSERT_IMP(a_repl_byte, dout.valid && dout.is_replacement, out_repl_ok, "bad replacement byte")

endmodule

// ===== design/utf8_sanitizer.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitizer
// Byte-serial UTF-8 validator; malformed starts become U+FFFD.
// ----------------------------------------------------------------------------
// channel  dir  payload                                               word
// din      in   in_byte[7:0], text_end                                one raw byte
// dout     out  out_byte[7:0], run_last, is_replacement, text_done,   one result byte
//               text_valid
//
// One input byte at a time: a load state, then per sequence a classify state
// and an emit state that walks its output bytes (3 for a replacement), then
// a classify state that finds the buffer empty or held and a close state.
// Results leave through a lookahead stage and an output register; dout
// stalls hold the sequencer. din is ready only between steps.
// Reset clears the held-byte count, the error flag and all valid flags.
// ----------------------------------------------------------------------------
module utf8_sanitizer (
	input  logic       clk,
	input  logic       arst_n,
	u8s_in_if.sink     din,
	u8s_out_if.source  dout
);

	u8s_pkg::cmd_t cmd;
	u8s_pkg::sts_t sts;

	u8s_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	u8s_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (din.in_byte),
		.text_end (din.text_end),
		.cmd      (cmd),
		.sts      (sts),
		.dout     (dout)
	);

endmodule

// ===== tb/sv/utf8_sanitizer_checker.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitizer_checker
// Watches both channels of the sanitizer, predicts the output words of every
// accepted input byte and compares them in order, field by field.
// ----------------------------------------------------------------------------
module utf8_sanitizer_checker (
	input  logic        clk,
	input  logic        arst_n,
	u8s_in_if           din,
	u8s_out_if          dout,
	output int unsigned errors,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       is_replacement;
		logic       text_done;
		logic       text_valid;
	} word_t;

	word_t       expected_words[$];
	word_t       head;
	logic [7:0]  held[3];
	int unsigned held_cnt = 0;
	bit          text_bad = 0;
	int unsigned fail_cnt = 0;

	assign errors = fail_cnt;

	function automatic int unsigned seq_len(input logic [7:0] b);
		if (!b[7])
			return 1;
		if (b[7:5] == 3'b110)
			return 2;
		if (b[7:4] == 4'b1110)
			return 3;
		if (b[7:3] == 5'b11110)
			return 4;
		return 0;
	endfunction

	function automatic void push_word(input logic [7:0] b, input logic repl);
		word_t w;
		w = '0;
		w.out_byte = b;
		w.is_replacement = repl;
		expected_words = {expected_words, w};
	endfunction

	task automatic sanitize_byte(input logic [7:0] b_in, input logic last);
		logic [7:0]  seq[4];
		logic [20:0] cp;
		int unsigned len, pos, k, lim, i, first;
		bit          bad;
		word_t       w;
		len = 0;
		pos = 0;
		first = expected_words.size();
		for (i = 0; i < held_cnt; i++) begin
			seq[len] = held[i];
			len++;
		end
		seq[len] = b_in;
		len++;
		while (pos < len) begin
			k = seq_len(seq[pos]);
			bad = (k == 0);
			if (k == 1) begin
				push_word(seq[pos], 1'b0);
				pos++;
				continue;
			end
			if (!bad) begin
				lim = (len - pos < k) ? len - pos : k;
				for (i = 1; i < lim; i++)
					if (seq[pos + i][7:6] != 2'b10)
						bad = 1;
				// incomplete but intact: hold it unless the text ends here
				if (!bad && len - pos < k) begin
					if (last)
						bad = 1;
					else
						break;
				end
			end
			if (!bad) begin
				case (k)
				2: cp = 21'(seq[pos][4:0]);
				3: cp = 21'(seq[pos][3:0]);
				default: cp = 21'(seq[pos][2:0]);
				endcase
				for (i = 1; i < k; i++)
					cp = (cp << 6) | 21'(seq[pos + i][5:0]);
				bad = (k == 2 && cp < 21'h80) || (k == 3 && cp < 21'h800) ||
					(k == 4 && (cp < 21'h10000 || cp > 21'h10ffff)) ||
					(cp >= 21'hd800 && cp <= 21'hdfff);
				if (!bad) begin
					for (i = 0; i < k; i++)
						push_word(seq[pos + i], 1'b0);
					pos += k;
					continue;
				end
			end
			push_word(u8s_pkg::REPL_B0, 1'b1);
			push_word(u8s_pkg::REPL_B1, 1'b1);
			push_word(u8s_pkg::REPL_B2, 1'b1);
			text_bad = 1;
			pos++;
		end
		if (last) begin
			held_cnt = 0;
		end else begin
			held_cnt = len - pos;
			for (i = 0; i < held_cnt; i++)
				held[i] = seq[pos + i];
		end
		if (expected_words.size() > first) begin
			w = expected_words.pop_back();
			w.run_last = 1'b1;
			if (last) begin
				w.text_done = 1'b1;
				w.text_valid = !text_bad;
			end
			expected_words = {expected_words, w};
		end
		if (last)
			text_bad = 0;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			fail_cnt++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			held_cnt = 0;
			text_bad = 0;
			outstanding = 0;
		end else begin
			if (din.valid && din.ready)
				sanitize_byte(din.in_byte, din.text_end);
			if (dout.valid && dout.ready) begin
				if (expected_words.size() == 0) begin
					fail_cnt++;
					$display("%0t: word %0h expected none, got one", $time, dout.out_byte);
				end else begin
					head = expected_words.pop_front();
					check_field("out_byte", head.out_byte, dout.out_byte);
					check_field("run_last", 8'(head.run_last), 8'(dout.run_last));
					check_field("is_replacement", 8'(head.is_replacement),
						8'(dout.is_replacement));
					check_field("text_done", 8'(head.text_done), 8'(dout.text_done));
					check_field("text_valid", 8'(head.text_valid), 8'(dout.text_valid));
				end
			end
			outstanding = expected_words.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives texts of well-formed and malformed UTF-8 into the sanitizer under
// random sender gaps and receiver stalls; the checker judges every word.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned cycles = 0;
	int unsigned errors;
	int unsigned outstanding;
	logic [8:0]  text_q[$];

	logic [8:0] directed_words[24] = '{
		9'h000, 9'h07f, 9'h0c2, 9'h080, 9'h0df, 9'h0bf, 9'h0f4, 9'h08f, 9'h0bf, 9'h1bf,
		9'h0c1, 9'h0bf, 9'h0ed, 9'h0a0, 9'h080, 9'h0f4, 9'h090, 9'h080, 9'h080,
		9'h0e2, 9'h041, 9'h0ff, 9'h0e2, 9'h182
	};

	u8s_in_if  din();
	u8s_out_if dout();

	utf8_sanitizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	utf8_sanitizer_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.din         (din),
		.dout        (dout),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk)
		dout.ready <= ($urandom_range(99) >= stall_pct);

	function automatic logic [20:0] pick_cp(input int unsigned k);
		logic [20:0] cp;
		case (k)
		1: cp = 21'($urandom_range(8'h7f, 0));
		2: cp = 21'($urandom_range(16'h7ff, 16'h80));
		3: begin
			cp = 21'($urandom_range(16'hffff, 16'h800));
			if (cp >= 21'hd800 && cp <= 21'hdfff)
				cp ^= 21'h1000;
		end
		default: cp = 21'($urandom_range(21'h10ffff, 21'h10000));
		endcase
		return cp;
	endfunction

	// first byte in [31:24]
	function automatic logic [31:0] encode(input logic [20:0] cp, input int unsigned k);
		case (k)
		1: return {cp[7:0], 24'h0};
		2: return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
		3: return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
		default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10,
			cp[5:0]};
		endcase
	endfunction

	task automatic add_char();
		int unsigned k, n, i;
		logic [31:0] seq;
		k = $urandom_range(4, 1);
		n = k;
		seq = encode(pick_cp(k), k);
		if ($urandom_range(99) >= 70) begin
			case ($urandom_range(7, 0))
			0: begin
				n = 2;
				seq = encode(21'($urandom_range(8'h7f, 0)), 2);
			end
			1: begin
				n = 3;
				seq = encode(21'($urandom_range(16'h7ff, 0)), 3);
			end
			2: begin
				n = 4;
				seq = encode(21'($urandom_range(16'hffff, 0)), 4);
			end
			3: begin
				n = 3;
				seq = encode(21'($urandom_range(16'hdfff, 16'hd800)), 3);
			end
			4: begin
				n = 4;
				seq = encode(21'($urandom_range(21'h1fffff, 21'h110000)), 4);
			end
			5: begin
				k = $urandom_range(4, 2);
				seq = encode(pick_cp(k), k);
				n = $urandom_range(k - 1, 1);
			end
			6: begin
				n = 1;
				seq = $urandom_range(1) ? {8'($urandom_range(8'hff, 8'hf8)), 24'h0} :
					{8'($urandom_range(8'hbf, 8'h80)), 24'h0};
			end
			default: begin
				n = 1;
				seq = {8'($urandom_range(8'hff, 0)), 24'h0};
			end
			endcase
		end
		for (i = 0; i < n; i++)
			text_q = {text_q, {1'b0, seq[31 - 8 * i -: 8]}};
	endtask

	task automatic add_text();
		logic [8:0] last;
		repeat ($urandom_range(12, 1))
			add_char();
		last = text_q.pop_back();
		text_q = {text_q, {1'b1, last[7:0]}};
	endtask

	// valid stays high across back-to-back words
	task automatic send_word(input logic [8:0] w);
		if ($urandom_range(99) < gap_pct) begin
			din.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
		din.valid <= 1'b1;
		din.text_end <= w[8];
		din.in_byte <= w[7:0];
		@(posedge clk);
		while (!din.ready)
			@(posedge clk);
	endtask

	task automatic run_phase(input int unsigned gap, input int unsigned stall,
		input int unsigned target);
		gap_pct = gap;
		stall_pct = stall;
		while (text_q.size() < target)
			add_text();
		while (text_q.size() != 0)
			send_word(text_q.pop_front());
	endtask

	initial begin
		gap_pct = 12;
		stall_pct = 47;
		arst_n <= 1'b0;
		din.valid <= 1'b0;
		din.in_byte <= 8'h00;
		din.text_end <= 1'b0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_words[i])
			text_q = {text_q, directed_words[i]};
		run_phase(12, 47, 107);
		run_phase(47, 12, 107);
		run_phase(0, 0, 107);
		din.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (40)
			@(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== utf8_sanitizer.f =====
+incdir+design
design/u8s_pkg.sv
design/u8s_in_if.sv
design/u8s_out_if.sv
design/u8s_ctrl.sv
design/u8s_dp.sv
design/utf8_sanitizer.sv
tb/sv/utf8_sanitizer_checker.sv
tb/sv/testbench.sv
